/* sv/depq_pkg.sv */
`timescale 1ns / 1ps

package depq_pkg;

   // word field widths
   localparam int DATA_W   = 32;
   localparam int MODE_W   = 2;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   // default store depth
   localparam int CAPACITY_DEF = 1024;

   // operation codes carried in req_mode
   localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REM_MAX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REM_MIN = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // datapath micro-operations issued by the controller
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_INS_FIRST,
      ACT_INS_START,
      ACT_SHIFT_MOVE,
      ACT_SHIFT_LAST,
      ACT_PLACE,
      ACT_FULL,
      ACT_EMPTY_RM,
      ACT_RM_LAST,
      ACT_RM_MAX,
      ACT_RM_MIN,
      ACT_LOAD_MAX,
      ACT_LOAD_MIN,
      ACT_CLEAR
   } dp_act_type;

   typedef struct packed {
      dp_act_type act;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_one;
      logic full;
      logic ptr_one;
      logic greater;
   } dp_sts_type;

endpackage

/* sv/double_ended_priority_queue_core.sv */
`timescale 1ns / 1ps
// Result word: registered from S_DONE once the output is free. Clear, empty removal,
//   last-entry removal and full or first insert go straight to S_DONE; other removals
//   read the RAM in S_FETCH_MAX/S_FETCH_MIN; other inserts shift each larger entry up
//   in S_SHIFT, one shift a cycle through the single write port of the entry RAM.
// Throughput: one word in flight; the next is taken once its result word is registered,
//   later while a result word is stalled. Reset (sync, active high) empties the queue.

module double_ended_priority_queue_core #(
   parameter int CAPACITY = depq_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [depq_pkg::MODE_W-1:0]           req_mode,
   input  logic signed [depq_pkg::DATA_W-1:0]    req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_is_empty,
   output logic signed [depq_pkg::DATA_W-1:0]    rsp_largest,
   output logic signed [depq_pkg::DATA_W-1:0]    rsp_smallest,
   output logic [depq_pkg::COUNT_W-1:0]          rsp_entry_count,
   output logic [depq_pkg::STATUS_W-1:0]         rsp_status
);

   depq_pkg::dp_cmd_type cmd;
   depq_pkg::dp_sts_type sts;

   depq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   depq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_value       (req_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_largest     (rsp_largest),
      .rsp_smallest    (rsp_smallest),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

endmodule

/* sv/depq_ram.sv */
`timescale 1ns / 1ps

module depq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/depq_dp.sv */
`timescale 1ns / 1ps

module depq_dp #(
   parameter int CAPACITY = depq_pkg::CAPACITY_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  depq_pkg::dp_cmd_type                   cmd,
   output depq_pkg::dp_sts_type                   sts,
   input  logic signed [depq_pkg::DATA_W-1:0]     req_value,
   output logic                                   rsp_is_empty,
   output logic signed [depq_pkg::DATA_W-1:0]     rsp_largest,
   output logic signed [depq_pkg::DATA_W-1:0]     rsp_smallest,
   output logic [depq_pkg::COUNT_W-1:0]           rsp_entry_count,
   output logic [depq_pkg::STATUS_W-1:0]          rsp_status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW:0]   CAP_EXT = CAPACITY[CW:0];
   localparam logic [CW-1:0] CAP_C   = CAPACITY[CW-1:0];
   localparam logic [CW-1:0] ZERO_C  = '0;
   localparam logic [CW-1:0] ONE_C   = CW'(1);
   localparam logic [CW-1:0] TWO_C   = CW'(2);

   // ring bookkeeping: entries sit ascending from head_ff
   logic [AW-1:0]                       head_ff, head_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [CW-1:0]                       ptr_ff, ptr_in;
   logic signed [depq_pkg::DATA_W-1:0]  value_ff, value_in;
   logic signed [depq_pkg::DATA_W-1:0]  min_ff, min_in;
   logic signed [depq_pkg::DATA_W-1:0]  max_ff, max_in;
   logic [depq_pkg::STATUS_W-1:0]       status_ff, status_in;

   // result word registers
   logic                                rsp_is_empty_ff;
   logic signed [depq_pkg::DATA_W-1:0]  rsp_largest_ff;
   logic signed [depq_pkg::DATA_W-1:0]  rsp_smallest_ff;
   logic [depq_pkg::COUNT_W-1:0]        rsp_entry_count_ff;
   logic [depq_pkg::STATUS_W-1:0]       rsp_status_ff;

   // memory port
   logic                                wr_en;
   logic [AW-1:0]                       wr_addr;
   logic [depq_pkg::DATA_W-1:0]         wr_data;
   logic                                rd_en;
   logic [AW-1:0]                       rd_addr;
   logic [depq_pkg::DATA_W-1:0]         rd_data;
   logic signed [depq_pkg::DATA_W-1:0]  rd_value;

   logic [CW+depq_pkg::COUNT_W-1:0]     count_ext;

   // physical address of a logical offset, wrapped once
   function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
      if (sum >= CAP_EXT) begin
         sum = sum - CAP_EXT;
      end
      return sum[AW-1:0];
   endfunction

   depq_ram #(
      .WIDTH (depq_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_value = $signed(rd_data);

   // status back to the controller
   always_comb begin
      sts.count_zero = (count_ff == ZERO_C);
      sts.count_one  = (count_ff == ONE_C);
      sts.full       = (count_ff == CAP_C);
      sts.ptr_one    = (ptr_ff == ONE_C);
      sts.greater    = (rd_value > value_ff);
   end

   // micro-operation decode
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      value_in  = value_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      case (cmd.act)
         depq_pkg::ACT_INS_FIRST: begin
            wr_en     = 1'b1;
            wr_addr   = ring(head_ff, ZERO_C);
            wr_data   = req_value;
            count_in  = count_ff + ONE_C;
            min_in    = req_value;
            max_in    = req_value;
            status_in = depq_pkg::ST_DONE;
         end
         depq_pkg::ACT_INS_START: begin
            value_in  = req_value;
            ptr_in    = count_ff;
            rd_en     = 1'b1;
            rd_addr   = ring(head_ff, count_ff - ONE_C);
            count_in  = count_ff + ONE_C;
            min_in    = (req_value < min_ff) ? req_value : min_ff;
            max_in    = (req_value > max_ff) ? req_value : max_ff;
            status_in = depq_pkg::ST_DONE;
         end
         depq_pkg::ACT_SHIFT_MOVE: begin
            // move the larger entry up, fetch the next one down
            wr_en   = 1'b1;
            wr_addr = ring(head_ff, ptr_ff);
            wr_data = rd_data;
            rd_en   = 1'b1;
            rd_addr = ring(head_ff, ptr_ff - TWO_C);
            ptr_in  = ptr_ff - ONE_C;
         end
         depq_pkg::ACT_SHIFT_LAST: begin
            wr_en   = 1'b1;
            wr_addr = ring(head_ff, ptr_ff);
            wr_data = rd_data;
            ptr_in  = ptr_ff - ONE_C;
         end
         depq_pkg::ACT_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = ring(head_ff, ptr_ff);
            wr_data = value_ff;
         end
         depq_pkg::ACT_FULL: begin
            status_in = depq_pkg::ST_FULL;
         end
         depq_pkg::ACT_EMPTY_RM: begin
            status_in = depq_pkg::ST_EMPTY;
         end
         depq_pkg::ACT_RM_LAST: begin
            count_in  = count_ff - ONE_C;
            status_in = depq_pkg::ST_DONE;
         end
         depq_pkg::ACT_RM_MAX: begin
            count_in  = count_ff - ONE_C;
            rd_en     = 1'b1;
            rd_addr   = ring(head_ff, count_ff - TWO_C);
            status_in = depq_pkg::ST_DONE;
         end
         depq_pkg::ACT_RM_MIN: begin
            head_in   = ring(head_ff, ONE_C);
            count_in  = count_ff - ONE_C;
            rd_en     = 1'b1;
            rd_addr   = ring(head_ff, ONE_C);
            status_in = depq_pkg::ST_DONE;
         end
         depq_pkg::ACT_LOAD_MAX: begin
            max_in = rd_value;
         end
         depq_pkg::ACT_LOAD_MIN: begin
            min_in = rd_value;
         end
         depq_pkg::ACT_CLEAR: begin
            count_in  = ZERO_C;
            status_in = depq_pkg::ST_DONE;
         end
         default: begin
         end
      endcase
   end

   assign count_ext = {{depq_pkg::COUNT_W{1'b0}}, count_ff};

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      ptr_ff    <= ptr_in;
      value_ff  <= value_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
      status_ff <= status_in;
      if (cmd.emit) begin
         rsp_is_empty_ff    <= (count_ff == ZERO_C);
         rsp_largest_ff     <= (count_ff == ZERO_C) ? '0 : max_ff;
         rsp_smallest_ff    <= (count_ff == ZERO_C) ? '0 : min_ff;
         rsp_entry_count_ff <= count_ext[depq_pkg::COUNT_W-1:0];
         rsp_status_ff      <= status_ff;
      end
   end

   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_largest     = rsp_largest_ff;
   assign rsp_smallest    = rsp_smallest_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

/* sv/depq_ctrl.sv */
`timescale 1ns / 1ps

module depq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [depq_pkg::MODE_W-1:0]   req_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output depq_pkg::dp_cmd_type          cmd,
   input  depq_pkg::dp_sts_type          sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_PLACE,
      S_FETCH_MAX,
      S_FETCH_MIN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequencing of micro-operations
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.act      = depq_pkg::ACT_NONE;
      cmd.emit     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DONE;
               case (req_mode)
                  depq_pkg::MODE_INSERT: begin
                     if (sts.full) begin
                        cmd.act = depq_pkg::ACT_FULL;
                     end else if (sts.count_zero) begin
                        cmd.act = depq_pkg::ACT_INS_FIRST;
                     end else begin
                        cmd.act  = depq_pkg::ACT_INS_START;
                        state_in = S_SHIFT;
                     end
                  end
                  depq_pkg::MODE_REM_MAX: begin
                     if (sts.count_zero) begin
                        cmd.act = depq_pkg::ACT_EMPTY_RM;
                     end else if (sts.count_one) begin
                        cmd.act = depq_pkg::ACT_RM_LAST;
                     end else begin
                        cmd.act  = depq_pkg::ACT_RM_MAX;
                        state_in = S_FETCH_MAX;
                     end
                  end
                  depq_pkg::MODE_REM_MIN: begin
                     if (sts.count_zero) begin
                        cmd.act = depq_pkg::ACT_EMPTY_RM;
                     end else if (sts.count_one) begin
                        cmd.act = depq_pkg::ACT_RM_LAST;
                     end else begin
                        cmd.act  = depq_pkg::ACT_RM_MIN;
                        state_in = S_FETCH_MIN;
                     end
                  end
                  default: begin
                     cmd.act = depq_pkg::ACT_CLEAR;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // entry below the slot is larger: move it up
            if (sts.greater) begin
               if (sts.ptr_one) begin
                  cmd.act  = depq_pkg::ACT_SHIFT_LAST;
                  state_in = S_PLACE;
               end else begin
                  cmd.act = depq_pkg::ACT_SHIFT_MOVE;
               end
            end else begin
               cmd.act  = depq_pkg::ACT_PLACE;
               state_in = S_DONE;
            end
         end
         S_PLACE: begin
            cmd.act  = depq_pkg::ACT_PLACE;
            state_in = S_DONE;
         end
         S_FETCH_MAX: begin
            cmd.act  = depq_pkg::ACT_LOAD_MAX;
            state_in = S_DONE;
         end
         S_FETCH_MIN: begin
            cmd.act  = depq_pkg::ACT_LOAD_MIN;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
